@@ rtl/core/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// Coin head-count distribution: shared package
// Word types, fixed-point constants and default sizes for the
// distribution core.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int DEF_MAX_COINS = 1024;

  localparam int PROB_W  = 17;
  localparam int DIST_W  = 33;
  localparam int TOTAL_W = 11;

  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h1_0000;
  localparam logic [DIST_W-1:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic [PROB_W-1:0] coin_prob;
    logic              last_coin;
  } coin_t;

  typedef struct packed {
    logic [DIST_W-1:0]  majority_prob;
    logic [TOTAL_W-1:0] coin_total;
    logic               too_many;
  } result_t;

endpackage

@@ rtl/core/coin_heads_distribution_dp_core.sv @@
// ----------------------------------------------------------------------------
// Coin head-count distribution core
// Folds coin head probabilities into a stored head-count distribution and
// reports the probability of a majority of heads after the last coin.
// ----------------------------------------------------------------------------
// Usage: a coin word is taken at a rising edge where start is high and busy
// is low. Each word carries a Q1.16 head probability and a last-coin flag.
// The distribution lives in one synchronous memory of MAX_COINS+1 entries.
// Folding a coin sweeps the live entries from the top down through a
// read, multiply and write-back pipeline, so a coin keeps the core busy
// until the sweep over the memory port is through; no new coin is taken
// before then. A coin beyond capacity is only flagged and, unless it is a
// last coin, leaves the core idle. After a last coin the core reads entries
// ceil(n/2)..n, n being the coins folded, and accumulates them. The result
// word is then shown for exactly one cycle with done high; the receiver
// takes it at that edge and cannot hold it off. The core then returns to
// its empty state, ready for a new set of coins. Reset empties the
// distribution at once through the coin count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module coin_heads_distribution_dp_core #(
  parameter int MAX_COINS = chd_pkg::DEF_MAX_COINS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  chd_pkg::coin_t   coin,
  output logic             done,
  output chd_pkg::result_t result
);

  localparam int AW  = $clog2(MAX_COINS + 1);
  localparam int PW  = chd_pkg::PROB_W;
  localparam int DW  = chd_pkg::DIST_W;
  localparam int MW  = DW + PW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FOLD   = 3'd1;
  localparam logic [2:0] S_FDRAIN = 3'd2;
  localparam logic [2:0] S_SUM    = 3'd3;
  localparam logic [2:0] S_SDRAIN = 3'd4;

  logic [DW-1:0] dist_mem [0:MAX_COINS];

  logic [2:0]    state;
  logic [AW-1:0] coins_seen;
  logic          overflowed;
  logic          v1;
  logic          v2;

  logic [AW-1:0] idx;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rdata;
  logic          z1;
  logic          ov1;
  logic [AW-1:0] j1;
  logic [AW-1:0] j2;
  logic [PW-1:0] p_reg;
  logic [PW-1:0] q_reg;
  logic          last_reg;
  logic [DW-1:0] hold;
  logic [MW-1:0] prod_t;
  logic [MW-1:0] prod_h;
  logic [DW-1:0] acc;

  logic          accept;
  logic          fits;
  logic          fold_mode;
  logic [PW-1:0] p_sat;
  logic [DW-1:0] cur;
  logic [DW+1:0] fold_sum;
  logic [DW-1:0] fold_val;
  logic [DW:0]   acc_sum;
  logic [DW-1:0] acc_val;
  logic [AW:0]   thr_wide;
  logic [AW-1:0] thr;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign fits      = (coins_seen < AW'(MAX_COINS));
  assign fold_mode = (state == S_FOLD) || (state == S_FDRAIN);
  assign p_sat     = (coin.coin_prob > chd_pkg::ONE_Q16) ? chd_pkg::ONE_Q16 : coin.coin_prob;

  assign thr_wide = ({1'b0, coins_seen} + (AW + 1)'(1)) >> 1;
  assign thr      = thr_wide[AW-1:0];

  always_comb begin
    if (state == S_FOLD) begin
      rd_addr = (idx == '0) ? '0 : idx - AW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  assign cur = z1 ? '0 : (ov1 ? chd_pkg::ONE_Q32 : rdata);

  assign fold_sum = {1'b0, prod_t[MW-1:16]} + {1'b0, prod_h[MW-1:16]};
  assign fold_val = (fold_sum > (DW + 2)'(chd_pkg::ONE_Q32)) ? chd_pkg::ONE_Q32
                                                             : fold_sum[DW-1:0];

  assign acc_sum = {1'b0, acc} + {1'b0, cur};
  assign acc_val = (acc_sum > (DW + 1)'(chd_pkg::ONE_Q32)) ? chd_pkg::ONE_Q32
                                                           : acc_sum[DW-1:0];

  always_ff @(posedge clk) begin
    rdata <= dist_mem[rd_addr];
    if (v2) begin
      dist_mem[j2] <= fold_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      coins_seen <= '0;
      overflowed <= 1'b0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= 1'b0;
      v2   <= v1 && fold_mode;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (fits) begin
              state <= S_FOLD;
            end else begin
              overflowed <= 1'b1;
              if (coin.last_coin) begin
                state <= S_SUM;
              end
            end
          end
        end
        S_FOLD: begin
          v1 <= 1'b1;
          if (idx == '0) begin
            state <= S_FDRAIN;
          end
        end
        S_FDRAIN: begin
          if (!v1 && !v2) begin
            coins_seen <= coins_seen + AW'(1);
            state      <= last_reg ? S_SUM : S_IDLE;
          end
        end
        S_SUM: begin
          v1 <= 1'b1;
          if (idx == thr) begin
            state <= S_SDRAIN;
          end
        end
        S_SDRAIN: begin
          if (!v1) begin
            done       <= 1'b1;
            coins_seen <= '0;
            overflowed <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    z1  <= (state == S_FOLD) && (idx == '0);
    ov1 <= (rd_addr == '0) && (coins_seen == '0);
    j1  <= idx;
    case (state)
      S_IDLE: begin
        acc <= '0;
        if (accept) begin
          p_reg    <= p_sat;
          q_reg    <= chd_pkg::ONE_Q16 - p_sat;
          last_reg <= coin.last_coin;
          hold     <= '0;
          idx      <= fits ? coins_seen + AW'(1) : coins_seen;
        end
      end
      S_FOLD, S_SUM: begin
        if (idx != '0) begin
          idx <= idx - AW'(1);
        end
      end
      S_FDRAIN: begin
        idx <= coins_seen + AW'(1);
      end
      default: begin
      end
    endcase
    if (v1 && fold_mode) begin
      prod_t <= MW'(hold) * MW'(q_reg);
      prod_h <= MW'(cur) * MW'(p_reg);
      hold   <= cur;
      j2     <= j1;
    end
    if (v1 && !fold_mode) begin
      acc <= acc_val;
    end
    if ((state == S_SDRAIN) && !v1) begin
      result.majority_prob <= acc;
      result.coin_total    <= chd_pkg::TOTAL_W'(coins_seen);
      result.too_many      <= overflowed;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    coins_seen <= AW'(MAX_COINS))
    else $error("coin count exceeds capacity");

  a_done_after_sum: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_SDRAIN)
    else $error("result strobe without a finished majority sum");

  a_write_in_fold: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (state == S_FOLD) || (state == S_FDRAIN))
    else $error("distribution written outside a fold");

  a_fold_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && fits) |=> state == S_FOLD)
    else $error("accepted coin did not start a fold");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Coin head-count distribution core: testbench
// Drives coin words through the start/busy handshake with random gaps,
// folds each accepted coin into a distribution kept alongside the core,
// and compares every result word field by field with the predicted
// majority probability, coin total and capacity flag.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_COINS    = chd_pkg::DEF_MAX_COINS;
  localparam int PROB_W       = chd_pkg::PROB_W;
  localparam int DIST_W       = chd_pkg::DIST_W;
  localparam int TOTAL_W      = chd_pkg::TOTAL_W;
  localparam int ITEM_TARGET  = 580;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int DRAIN_CYCLES = 64;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  chd_pkg::coin_t   coin = '0;
  logic             done;
  chd_pkg::result_t result;

  chd_pkg::coin_t   coin_queue[$];
  chd_pkg::result_t pending_majority[$];
  chd_pkg::result_t want;

  logic [63:0] dist_model[0:MAX_COINS];
  int unsigned coins_model;
  logic        overflow_model;

  int coins_queued;
  int sets_queued;
  int coins_accepted;
  int results_checked;
  int fail_count;
  int cycle_count;
  int gap_left;
  int quiet_left;
  int roll;
  int set_roll;

  coin_heads_distribution_dp_core #(
    .MAX_COINS(MAX_COINS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .coin(coin),
    .done(done),
    .result(result)
  );

  function automatic logic [63:0] clip_one(logic [63:0] v);
    return (v > 64'(chd_pkg::ONE_Q32)) ? 64'(chd_pkg::ONE_Q32) : v;
  endfunction

  function automatic void clear_model();
    for (int h = 0; h <= MAX_COINS; h++) dist_model[h] = '0;
    dist_model[0] = 64'(chd_pkg::ONE_Q32);
    coins_model = 0;
    overflow_model = 1'b0;
  endfunction

  function automatic void fold_coin_model(chd_pkg::coin_t c);
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] tail;
    logic [63:0] head;
    logic [63:0] acc;
    int unsigned h;
    chd_pkg::result_t r;
    p = (c.coin_prob > chd_pkg::ONE_Q16) ? 64'(chd_pkg::ONE_Q16) : 64'(c.coin_prob);
    q = 64'(chd_pkg::ONE_Q16) - p;
    if (coins_model < MAX_COINS) begin
      dist_model[coins_model + 1] = (dist_model[coins_model] * p) >> 16;
      for (h = coins_model; h > 0; h--) begin
        tail = (dist_model[h] * q) >> 16;
        head = (dist_model[h - 1] * p) >> 16;
        dist_model[h] = clip_one(tail + head);
      end
      dist_model[0] = (dist_model[0] * q) >> 16;
      coins_model++;
    end else begin
      overflow_model = 1'b1;
    end
    if (c.last_coin) begin
      acc = '0;
      for (h = (coins_model + 1) / 2; h <= coins_model; h++) acc = clip_one(acc + dist_model[h]);
      r.majority_prob = acc[DIST_W-1:0];
      r.coin_total = coins_model[TOTAL_W-1:0];
      r.too_many = overflow_model;
      pending_majority.push_back(r);
      clear_model();
    end
  endfunction

  task automatic queue_coin(logic [PROB_W-1:0] prob, logic last);
    chd_pkg::coin_t c;
    c.coin_prob = prob;
    c.last_coin = last;
    coin_queue.push_back(c);
    if (last) sets_queued++;
  endtask

  // Probabilities lean toward the ends of the range and past one.
  task automatic queue_random_set(int n);
    logic [PROB_W-1:0] prob;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: prob = '0;
        1: prob = chd_pkg::ONE_Q16;
        2: prob = PROB_W'($urandom_range(131071, 65537));
        3: prob = PROB_W'($urandom_range(16));
        4: prob = chd_pkg::ONE_Q16 - PROB_W'($urandom_range(16));
        default: prob = PROB_W'($urandom_range(65536));
      endcase
      queue_coin(prob, i == n - 1);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_majority.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      coin <= '0;
      gap_left = 0;
      quiet_left = 0;
    end else begin
      if (start && !busy) begin
        fold_coin_model(coin);
        coins_accepted++;
        if (quiet_left > 0) begin
          quiet_left--;
          gap_left = 0;
        end else begin
          roll = $urandom_range(99);
          if (roll < 3) begin
            quiet_left = $urandom_range(60, 20);
            gap_left = 0;
          end else if (roll < 55) begin
            gap_left = 0;
          end else if (roll < 90) begin
            gap_left = $urandom_range(6, 1);
          end else begin
            gap_left = $urandom_range(80, 10);
          end
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (coin_queue.size() != 0) begin
          coin <= coin_queue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_majority.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %h", $time, result);
        fail_count++;
      end else begin
        want = pending_majority.pop_front();
        results_checked++;
        if (result.majority_prob !== want.majority_prob) begin
          $display("%0t: majority_prob expected %0d, got %0d", $time, want.majority_prob,
                   result.majority_prob);
          fail_count++;
        end
        if (result.coin_total !== want.coin_total) begin
          $display("%0t: coin_total expected %0d, got %0d", $time, want.coin_total,
                   result.coin_total);
          fail_count++;
        end
        if (result.too_many !== want.too_many) begin
          $display("%0t: too_many expected %0b, got %0b", $time, want.too_many, result.too_many);
          fail_count++;
        end
      end
    end
  end

  initial begin
    clear_model();

    queue_coin('0, 1'b1);
    queue_coin(chd_pkg::ONE_Q16, 1'b1);
    queue_coin(17'h1FFFF, 1'b1);
    queue_coin(17'h10001, 1'b1);
    queue_coin(17'h08000, 1'b1);
    queue_coin(chd_pkg::ONE_Q16, 1'b0);
    queue_coin(chd_pkg::ONE_Q16, 1'b1);
    queue_coin('0, 1'b0);
    queue_coin('0, 1'b1);
    queue_coin('0, 1'b0);
    queue_coin(17'h1FFFF, 1'b0);
    queue_coin(chd_pkg::ONE_Q16, 1'b1);
    queue_coin(17'h00001, 1'b0);
    queue_coin(17'h0FFFF, 1'b0);
    queue_coin(17'h08000, 1'b0);
    queue_coin(17'h1FFFF, 1'b1);
    queue_coin(17'h0AAAA, 1'b0);
    queue_coin(17'h15555, 1'b0);
    queue_coin(17'h05555, 1'b1);

    while (coin_queue.size() < ITEM_TARGET) begin
      set_roll = $urandom_range(99);
      if (set_roll < 80) queue_random_set($urandom_range(10, 1));
      else if (set_roll < 98) queue_random_set($urandom_range(40, 11));
      else queue_random_set($urandom_range(120, 41));
    end
    coins_queued = coin_queue.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (coins_accepted != coins_queued || pending_majority.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Folded %0d coin words in %0d sets, from single coins up to long sets.",
             coins_accepted, sets_queued);
    $display("Checked %0d result words in %0d cycles.", results_checked, cycle_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
